// ===== rtl/wpc_pkg.sv =====
// wpc_pkg: types, constants and tag lookup for the wav pcm header checker
// no dependencies; imported by wpc_regs, wpc_capture, wpc_judge, wpc_checker and the core

package wpc_pkg;

  // header geometry
  localparam int unsigned HdrLen = 40;
  localparam int unsigned PosW   = 6;

  // configuration port
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned PdataW       = 32;
  localparam logic [31:0] MinRateReset = 32'd8000;
  localparam logic [31:0] MaxRateReset = 32'd48000;

  typedef enum logic [0:0] {
    REG_MIN_RATE = 1'b0,
    REG_MAX_RATE = 1'b1
  } reg_idx_e;

  // checks in priority order, first failing one is reported
  typedef enum logic [3:0] {
    ERR_OK       = 4'd0,
    ERR_RIFF     = 4'd1,
    ERR_WAVE     = 4'd2,
    ERR_FMT      = 4'd3,
    ERR_DATA     = 4'd4,
    ERR_FMT_SIZE = 4'd5,
    ERR_FORMAT   = 4'd6,
    ERR_BITS     = 4'd7,
    ERR_CHANNELS = 4'd8,
    ERR_RATE     = 4'd9,
    ERR_ALIGN    = 4'd10
  } err_code_e;

  localparam logic [31:0] FmtSizePcm   = 32'd16;
  localparam logic [15:0] FormatPcm    = 16'd1;
  localparam logic [15:0] BitsPcm16    = 16'd16;

  // tag flag bits
  localparam int unsigned TagRiff = 0;
  localparam int unsigned TagWave = 1;
  localparam int unsigned TagFmt  = 2;
  localparam int unsigned TagData = 3;

  // captured header fields as seen by the judge
  typedef struct packed {
    logic [3:0]  tag_mismatch;
    logic [31:0] fmt_size;
    logic [15:0] format;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] bits;
  } hdr_fields_t;

  // capture stage to judge stage
  typedef struct packed {
    logic        done;   // last header byte leaves the capture stage
    logic        hold;   // result register cannot take a new result
  } stage_ctl_t;

  // tag byte expected at a header position, sel is zero outside the tags
  typedef struct packed {
    logic [3:0] sel;
    logic [7:0] exp_byte;
  } tag_chk_t;

  function automatic tag_chk_t tag_lookup(logic [PosW-1:0] pos);
    tag_chk_t t;
    t = '0;
    case (pos)
      6'd0:  begin t.sel = 4'b0001; t.exp_byte = 8'h52; end
      6'd1:  begin t.sel = 4'b0001; t.exp_byte = 8'h49; end
      6'd2:  begin t.sel = 4'b0001; t.exp_byte = 8'h46; end
      6'd3:  begin t.sel = 4'b0001; t.exp_byte = 8'h46; end
      6'd8:  begin t.sel = 4'b0010; t.exp_byte = 8'h57; end
      6'd9:  begin t.sel = 4'b0010; t.exp_byte = 8'h41; end
      6'd10: begin t.sel = 4'b0010; t.exp_byte = 8'h56; end
      6'd11: begin t.sel = 4'b0010; t.exp_byte = 8'h45; end
      6'd12: begin t.sel = 4'b0100; t.exp_byte = 8'h66; end
      6'd13: begin t.sel = 4'b0100; t.exp_byte = 8'h6D; end
      6'd14: begin t.sel = 4'b0100; t.exp_byte = 8'h74; end
      6'd15: begin t.sel = 4'b0100; t.exp_byte = 8'h20; end
      6'd36: begin t.sel = 4'b1000; t.exp_byte = 8'h64; end
      6'd37: begin t.sel = 4'b1000; t.exp_byte = 8'h61; end
      6'd38: begin t.sel = 4'b1000; t.exp_byte = 8'h74; end
      6'd39: begin t.sel = 4'b1000; t.exp_byte = 8'h61; end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/wpc_in_if.sv =====
// wpc_in_if: valid/ready channel carrying one header byte request
// no dependencies

interface wpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       first_byte;

  modport source (output valid, output header_byte, output first_byte, input ready);
  modport sink (input valid, input header_byte, input first_byte, output ready);
endinterface

// ===== rtl/wpc_out_if.sv =====
// wpc_out_if: valid/ready channel carrying one header check result request
// no dependencies

interface wpc_out_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [3:0]  error_code;
  logic [7:0]  channel_count;
  logic [31:0] rate_hz;

  modport source (output valid, output header_valid, output error_code,
                  output channel_count, output rate_hz, input ready);
  modport sink (input valid, input header_valid, input error_code,
                input channel_count, input rate_hz, output ready);
endinterface

// ===== rtl/wpc_regs.sv =====
// wpc_regs: apb-style configuration registers for the sample rate limits
// depends on wpc_pkg

module wpc_regs import wpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [31:0]       min_rate_o,
  output logic [31:0]       max_rate_o
);

  logic [31:0] min_rate_q, min_rate_d;
  logic [31:0] max_rate_q, max_rate_d;
  logic        wr_en;
  reg_idx_e    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // write decode
  always_comb begin
    min_rate_d = min_rate_q;
    max_rate_d = max_rate_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MIN_RATE: min_rate_d = pwdata;
        REG_MAX_RATE: max_rate_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q <= MinRateReset;
      max_rate_q <= MaxRateReset;
    end else begin
      min_rate_q <= min_rate_d;
      max_rate_q <= max_rate_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_MIN_RATE: prdata = min_rate_q;
      REG_MAX_RATE: prdata = max_rate_q;
      default:      prdata = '0;
    endcase
  end

  assign min_rate_o = min_rate_q;
  assign max_rate_o = max_rate_q;

endmodule

// ===== rtl/wpc_capture.sv =====
// wpc_capture: input register, byte position counter, tag compare and field capture
// depends on wpc_pkg and wpc_in_if

module wpc_capture import wpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpc_in_if.sink      in_if,
  input  stage_ctl_t  ctl_i,
  output logic        done_o,
  output logic        last_pending_o,
  output hdr_fields_t fields_o
);

  localparam logic [PosW-1:0] LastPos = PosW'(HdrLen - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] take_pos;
  logic            s1_valid_q, s1_valid_d;
  logic [PosW-1:0] s1_pos_q;
  logic [7:0]      s1_byte_q;
  logic            in_fire;
  logic            s1_fire;
  tag_chk_t        tag_chk;
  logic [3:0]      tag_next;
  logic [3:0]      tag_q;
  logic [31:0]     fmt_size_q;
  logic [15:0]     format_q;
  logic [15:0]     channels_q;
  logic [31:0]     rate_q;
  logic [15:0]     align_q;
  logic [15:0]     bits_q;

  // handshake: the stage moves unless the result register is blocked
  assign s1_fire     = s1_valid_q & ~ctl_i.hold;
  assign in_if.ready = ~s1_valid_q | ~ctl_i.hold;
  assign in_fire     = in_if.valid & in_if.ready;

  // position of the accepted byte, restart mark forces zero
  assign take_pos = in_if.first_byte ? '0 : pos_q;

  always_comb begin
    pos_d      = pos_q;
    s1_valid_d = s1_valid_q;
    if (s1_fire) s1_valid_d = 1'b0;
    if (in_fire) begin
      pos_d      = (take_pos == LastPos) ? '0 : take_pos + 1'b1;
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q  <= take_pos;
      s1_byte_q <= in_if.header_byte;
    end
  end

  // tag flags, cleared by byte zero
  assign tag_chk  = tag_lookup(s1_pos_q);
  assign tag_next = ((s1_pos_q == '0) ? 4'b0000 : tag_q)
                  | (tag_chk.sel & {4{s1_byte_q != tag_chk.exp_byte}});

  // little-endian field capture
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      tag_q <= tag_next;
      if (s1_pos_q >= 6'd16 && s1_pos_q < 6'd20) fmt_size_q[s1_pos_q[1:0]*8 +: 8] <= s1_byte_q;
      if (s1_pos_q >= 6'd20 && s1_pos_q < 6'd22) format_q[s1_pos_q[0]*8 +: 8] <= s1_byte_q;
      if (s1_pos_q >= 6'd22 && s1_pos_q < 6'd24) channels_q[s1_pos_q[0]*8 +: 8] <= s1_byte_q;
      if (s1_pos_q >= 6'd24 && s1_pos_q < 6'd28) rate_q[s1_pos_q[1:0]*8 +: 8] <= s1_byte_q;
      if (s1_pos_q >= 6'd32 && s1_pos_q < 6'd34) align_q[s1_pos_q[0]*8 +: 8] <= s1_byte_q;
      if (s1_pos_q >= 6'd34 && s1_pos_q < 6'd36) bits_q[s1_pos_q[0]*8 +: 8] <= s1_byte_q;
    end
  end

  // the last byte is a tag byte, all numeric fields are already held
  assign done_o         = s1_fire & (s1_pos_q == LastPos);
  assign last_pending_o = s1_valid_q & (s1_pos_q == LastPos);

  assign fields_o.tag_mismatch = tag_next;
  assign fields_o.fmt_size     = fmt_size_q;
  assign fields_o.format       = format_q;
  assign fields_o.channels     = channels_q;
  assign fields_o.rate         = rate_q;
  assign fields_o.align        = align_q;
  assign fields_o.bits         = bits_q;

endmodule

// ===== rtl/wpc_judge.sv =====
// wpc_judge: header checks in priority order and the result register
// depends on wpc_pkg and wpc_out_if

module wpc_judge import wpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        done_i,
  input  logic        last_pending_i,
  input  hdr_fields_t fields_i,
  input  logic [31:0] min_rate_i,
  input  logic [31:0] max_rate_i,
  output stage_ctl_t  ctl_o,
  wpc_out_if.source   out_if
);

  logic        out_valid_q, out_valid_d;
  logic        valid_q;
  err_code_e   code_q, code;
  logic [7:0]  chan_q, ch;
  logic [31:0] rate_q;
  logic [8:0]  align_exp;

  assign ch        = fields_i.channels[7:0];
  assign align_exp = {ch, 1'b0};

  // first failing check wins
  always_comb begin
    if (fields_i.tag_mismatch[TagRiff])                  code = ERR_RIFF;
    else if (fields_i.tag_mismatch[TagWave])             code = ERR_WAVE;
    else if (fields_i.tag_mismatch[TagFmt])              code = ERR_FMT;
    else if (fields_i.tag_mismatch[TagData])             code = ERR_DATA;
    else if (fields_i.fmt_size != FmtSizePcm)            code = ERR_FMT_SIZE;
    else if (fields_i.format != FormatPcm)               code = ERR_FORMAT;
    else if (fields_i.bits != BitsPcm16)                 code = ERR_BITS;
    else if (ch < 8'd1 || ch > 8'd2)                     code = ERR_CHANNELS;
    else if (fields_i.rate < min_rate_i || fields_i.rate > max_rate_i)
                                                         code = ERR_RATE;
    else if (fields_i.align != {7'd0, align_exp})        code = ERR_ALIGN;
    else                                                 code = ERR_OK;
  end

  // stall the capture stage only when a second result would overrun
  assign ctl_o.hold = last_pending_i & out_valid_q & ~out_if.ready;
  assign ctl_o.done = done_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_if.ready) out_valid_d = 1'b0;
    if (done_i)       out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (done_i) begin
      valid_q <= (code == ERR_OK);
      code_q  <= code;
      chan_q  <= ch;
      rate_q  <= fields_i.rate;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.header_valid  = valid_q;
  assign out_if.error_code    = code_q;
  assign out_if.channel_count = chan_q;
  assign out_if.rate_hz       = rate_q;

endmodule

// ===== rtl/wav_pcm_header_checker_core.sv =====
// wav_pcm_header_checker_core: one header byte request per cycle unless stalled, one result per 40 bytes
// byte 39 passes the input register, then its result is written to the result register
// throughput: one byte per cycle; the only stall is byte 39 while the last result still waits
// reset: asynchronous active low, clears byte position, valid flags and sets rate limits
// depends on wpc_pkg, wpc_in_if, wpc_out_if, wpc_regs, wpc_capture, wpc_judge

module wav_pcm_header_checker_core import wpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  wpc_in_if.sink            in_if,
  wpc_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [31:0] min_rate;
  logic [31:0] max_rate;
  logic        done;
  logic        last_pending;
  hdr_fields_t fields;
  stage_ctl_t  ctl;

  // configuration registers
  wpc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .min_rate_o (min_rate),
    .max_rate_o (max_rate)
  );

  // byte intake and field capture, flags the last header byte waiting in its register
  wpc_capture u_capture (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .ctl_i          (ctl),
    .done_o         (done),
    .last_pending_o (last_pending),
    .fields_o       (fields)
  );

  // checks and result register
  wpc_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .done_i         (done),
    .last_pending_i (last_pending),
    .fields_i       (fields),
    .min_rate_i     (min_rate),
    .max_rate_i     (max_rate),
    .ctl_o          (ctl),
    .out_if         (out_if)
  );

endmodule

// ===== rtl/wpc_checker.sv =====
// wpc_checker: port-level assertions for wav_pcm_header_checker_core, bound to the top
// depends on wpc_pkg and the top level port names

module wpc_checker import wpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        header_valid,
  input logic [3:0]  error_code,
  input logic [7:0]  channel_count,
  input logic [31:0] rate_hz
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(error_code) && $stable(rate_hz))
    else $error("result changed while stalled");

  // valid flag and code agree
  a_valid_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (header_valid == (error_code == ERR_OK)))
    else $error("header_valid disagrees with error_code");

  // a passing header has one or two channels
  a_valid_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && header_valid |-> (channel_count == 8'd1 || channel_count == 8'd2))
    else $error("valid header with bad channel count");

  // a new result rises only after a request was accepted, passing the input and result registers
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding request");

endmodule

bind wav_pcm_header_checker_core wpc_checker u_wpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .header_valid  (out_if.header_valid),
  .error_code    (out_if.error_code),
  .channel_count (out_if.channel_count),
  .rate_hz       (out_if.rate_hz)
);
